// ----- sv/slash_command_token_parser_defines.svh -----
// assertion macros shared by the parser modules
`ifndef SLASH_COMMAND_TOKEN_PARSER_DEFINES_SVH
`define SLASH_COMMAND_TOKEN_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scp assertion failed");
`define SCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scp assertion failed");
`else
`define SCP_ASSERT_IMP(lbl, ante, cons)
`define SCP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/scp_pkg.sv -----
`timescale 1ns / 1ps
package scp_pkg;

  localparam int MAX_VALUES      = 8;
  localparam int MAX_TOKEN_CHARS = 8;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic        is_value;
    logic [15:0] number;
    logic        final_result;
    logic        parse_ok;
    logic [1:0]  request_kind;
    logic [1:0]  section;
    logic [1:0]  detail_one;
    logic [2:0]  detail_two;
    logic [3:0]  values_seen;
  } result_t;

  // up to two results come out of one byte
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ----- sv/scp_cmd_if.sv -----
`timescale 1ns / 1ps
interface scp_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_message;

  modport source (output valid, output char_in, output end_of_message, input ready);
  modport sink (input valid, input char_in, input end_of_message, output ready);
endinterface

// ----- sv/scp_res_if.sv -----
`timescale 1ns / 1ps
interface scp_res_if;
  logic        valid;
  logic        ready;
  logic        is_value;
  logic [15:0] number;
  logic        final_result;
  logic        parse_ok;
  logic [1:0]  request_kind;
  logic [1:0]  section;
  logic [1:0]  detail_one;
  logic [2:0]  detail_two;
  logic [3:0]  values_seen;

  modport source (
    output valid, output is_value, output number, output final_result, output parse_ok,
    output request_kind, output section, output detail_one, output detail_two,
    output values_seen, input ready
  );
  modport sink (
    input valid, input is_value, input number, input final_result, input parse_ok,
    input request_kind, input section, input detail_one, input detail_two,
    input values_seen, output ready
  );
endinterface

// ----- sv/scp_core.sv -----
`timescale 1ns / 1ps
`include "slash_command_token_parser_defines.svh"
module scp_core
  import scp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       end_of_message,
  output push_t      push
);

  typedef enum logic [2:0] {
    PH_HDR_START, PH_HDR_TOKEN, PH_VAL_START, PH_VAL_TOKEN, PH_FINISHED, PH_HALTED
  } phase_t;

  typedef enum logic [1:0] {SC_LEADING, SC_POSITIVE, SC_NEGATIVE, SC_STOPPED} sc_t;

  typedef struct packed {
    sc_t         sc;
    logic [15:0] acc;
  } scan_t;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [15:0] CODE_GT = 16'h6774;
  localparam logic [15:0] CODE_PT = 16'h7074;
  localparam logic [15:0] CODE_PG = 16'h7067;
  localparam logic [15:0] CODE_TM = 16'h746d;
  localparam logic [15:0] CODE_RL = 16'h726c;
  localparam logic [15:0] CODE_PN = 16'h706e;
  localparam logic [15:0] CODE_MD = 16'h6d64;
  localparam logic [15:0] CODE_ON = 16'h6f6e;
  localparam logic [15:0] CODE_OF = 16'h6f66;
  localparam logic [15:0] CODE_RT = 16'h7274;
  localparam logic [15:0] CODE_AC = 16'h6163;

  localparam logic [1:0] KIND_GET  = 2'd1;
  localparam logic [1:0] KIND_POST = 2'd2;
  localparam logic [1:0] KIND_PING = 2'd3;
  localparam logic [1:0] SEC_TIME  = 2'd1;
  localparam logic [1:0] SEC_RELAY = 2'd2;
  localparam logic [1:0] D1_PIN    = 2'd1;
  localparam logic [1:0] D1_MODE   = 2'd2;
  localparam logic [2:0] D2_ON     = 3'd1;
  localparam logic [2:0] D2_OFF    = 3'd2;
  localparam logic [2:0] D2_REPEAT = 3'd3;
  localparam logic [2:0] D2_ACTIVE = 3'd4;

  localparam logic [3:0] TOK_LIMIT = 4'(MAX_TOKEN_CHARS - 1);
  localparam logic [3:0] VAL_LIMIT = 4'(MAX_VALUES);

  phase_t      phase, phase_next;
  logic [3:0]  token_length, token_length_next;
  logic [15:0] first_two_chars, first_two_chars_next;
  logic [15:0] digit_accumulator, digit_accumulator_next;
  sc_t         sign_and_digits_seen, sign_and_digits_seen_next;
  logic        good_flag, good_flag_next;
  logic [1:0]  kind_reg, kind_reg_next;
  logic [1:0]  section_reg, section_reg_next;
  logic [1:0]  detail_one_reg, detail_one_reg_next;
  logic [2:0]  detail_two_reg, detail_two_reg_next;
  logic [3:0]  value_count, value_count_next;
  logic        emit_value;
  scan_t       scan_res;
  result_t     val_res, sum_res;

  // atoi-style step, one byte
  function automatic scan_t scan_byte(input sc_t sc, input logic [15:0] acc,
                                      input logic [7:0] ch);
    scan_t       r;
    logic        digit;
    logic [15:0] d;
    logic [15:0] acc10;
    r     = '{sc: sc, acc: acc};
    digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    d     = {12'd0, 4'(ch - CH_ZERO)};
    acc10 = {acc[12:0], 3'b000} + {acc[14:0], 1'b0};
    case (sc)
      SC_LEADING: begin
        if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
          r.sc = SC_LEADING;
        end else if (ch == CH_PLUS) begin
          r.sc = SC_POSITIVE;
        end else if (ch == CH_MINUS) begin
          r.sc = SC_NEGATIVE;
        end else if (digit) begin
          r.acc = d;
          r.sc  = SC_POSITIVE;
        end else begin
          r.sc = SC_STOPPED;
        end
      end
      SC_POSITIVE: begin
        if (digit) r.acc = acc10 + d;
        else r.sc = SC_STOPPED;
      end
      SC_NEGATIVE: begin
        if (digit) r.acc = acc10 - d;
        else r.sc = SC_STOPPED;
      end
      default: r = '{sc: sc, acc: acc};
    endcase
    return r;
  endfunction

  always_comb begin
    phase_next                = phase;
    token_length_next         = token_length;
    first_two_chars_next      = first_two_chars;
    digit_accumulator_next    = digit_accumulator;
    sign_and_digits_seen_next = sign_and_digits_seen;
    good_flag_next            = good_flag;
    kind_reg_next             = kind_reg;
    section_reg_next          = section_reg;
    detail_one_reg_next       = detail_one_reg;
    detail_two_reg_next       = detail_two_reg;
    value_count_next          = value_count;
    emit_value                = 1'b0;
    scan_res                  = '{sc: sign_and_digits_seen, acc: digit_accumulator};

    case (phase)
      PH_HDR_START: begin
        if (char_in == CH_SLASH) begin
          phase_next = PH_FINISHED;
        end else if (char_in == CH_EQ) begin
          phase_next = PH_VAL_START;
        end else begin
          first_two_chars_next = {char_in, 8'h00};
          token_length_next    = 4'd1;
          phase_next           = PH_HDR_TOKEN;
        end
      end
      PH_HDR_TOKEN: begin
        if (char_in == CH_SLASH) begin
          phase_next = PH_HDR_START;
          if (token_length != 4'd2) begin
            phase_next     = PH_HALTED;
            good_flag_next = 1'b0;
          end else begin
            case (first_two_chars)
              CODE_GT: kind_reg_next       = KIND_GET;
              CODE_PT: kind_reg_next       = KIND_POST;
              CODE_PG: kind_reg_next       = KIND_PING;
              CODE_TM: section_reg_next    = SEC_TIME;
              CODE_RL: section_reg_next    = SEC_RELAY;
              CODE_PN: detail_one_reg_next = D1_PIN;
              CODE_MD: detail_one_reg_next = D1_MODE;
              CODE_ON: detail_two_reg_next = D2_ON;
              CODE_OF: detail_two_reg_next = D2_OFF;
              CODE_RT: detail_two_reg_next = D2_REPEAT;
              CODE_AC: detail_two_reg_next = D2_ACTIVE;
              default: begin
                phase_next     = PH_HALTED;
                good_flag_next = 1'b0;
              end
            endcase
          end
        end else if (token_length >= TOK_LIMIT) begin
          phase_next     = PH_HALTED;
          good_flag_next = 1'b0;
        end else begin
          if (token_length == 4'd1) first_two_chars_next = {first_two_chars[15:8], char_in};
          token_length_next = token_length + 4'd1;
        end
      end
      PH_VAL_START: begin
        if (char_in == CH_SLASH) begin
          phase_next = PH_FINISHED;
        end else begin
          scan_res                  = scan_byte(SC_LEADING, 16'd0, char_in);
          digit_accumulator_next    = scan_res.acc;
          sign_and_digits_seen_next = scan_res.sc;
          token_length_next         = 4'd1;
          phase_next                = PH_VAL_TOKEN;
        end
      end
      PH_VAL_TOKEN: begin
        if (char_in == CH_SLASH) begin
          if (value_count < VAL_LIMIT) begin
            value_count_next = value_count + 4'd1;
            emit_value       = 1'b1;
            phase_next       = PH_VAL_START;
          end else begin
            phase_next     = PH_HALTED;
            good_flag_next = 1'b0;
          end
        end else if (token_length >= TOK_LIMIT) begin
          phase_next     = PH_HALTED;
          good_flag_next = 1'b0;
        end else begin
          scan_res                  = scan_byte(sign_and_digits_seen, digit_accumulator, char_in);
          digit_accumulator_next    = scan_res.acc;
          sign_and_digits_seen_next = scan_res.sc;
          token_length_next         = token_length + 4'd1;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_comb begin
    val_res = '{is_value: 1'b1, number: digit_accumulator, final_result: 1'b0,
                parse_ok: 1'b1, request_kind: kind_reg, section: section_reg,
                detail_one: detail_one_reg, detail_two: detail_two_reg,
                values_seen: value_count_next};
    sum_res = '{is_value: 1'b0, number: 16'd0, final_result: 1'b1,
                parse_ok: good_flag_next && (phase_next == PH_FINISHED),
                request_kind: kind_reg_next, section: section_reg_next,
                detail_one: detail_one_reg_next, detail_two: detail_two_reg_next,
                values_seen: value_count_next};
    push.first  = emit_value ? val_res : sum_res;
    push.second = sum_res;
    push.n      = 2'd0;
    if (accept) push.n = 2'({1'b0, emit_value} + {1'b0, end_of_message});
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_message)) begin
      phase                <= PH_HDR_START;
      token_length         <= 4'd0;
      first_two_chars      <= 16'd0;
      digit_accumulator    <= 16'd0;
      sign_and_digits_seen <= SC_LEADING;
      good_flag            <= 1'b1;
      kind_reg             <= 2'd0;
      section_reg          <= 2'd0;
      detail_one_reg       <= 2'd0;
      detail_two_reg       <= 3'd0;
      value_count          <= 4'd0;
    end else if (accept) begin
      phase                <= phase_next;
      token_length         <= token_length_next;
      first_two_chars      <= first_two_chars_next;
      digit_accumulator    <= digit_accumulator_next;
      sign_and_digits_seen <= sign_and_digits_seen_next;
      good_flag            <= good_flag_next;
      kind_reg             <= kind_reg_next;
      section_reg          <= section_reg_next;
      detail_one_reg       <= detail_one_reg_next;
      detail_two_reg       <= detail_two_reg_next;
      value_count          <= value_count_next;
    end
  end

  `SCP_ASSERT_IMP(a_count_limit, 1'b1, value_count <= VAL_LIMIT)
  `SCP_ASSERT_IMP(a_halt_bad, phase == PH_HALTED, !good_flag)
  `SCP_ASSERT_NXT(a_msg_clear, accept && end_of_message,
                  phase == PH_HDR_START && value_count == 4'd0 && good_flag)
  `SCP_ASSERT_IMP(a_two_means_last, push.n == 2'd2, end_of_message && emit_value)

endmodule

// ----- sv/scp_res_queue.sv -----
`timescale 1ns / 1ps
`include "slash_command_token_parser_defines.svh"
module scp_res_queue
  import scp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output logic    room,
  output logic    valid,
  output result_t head
);

  result_t                mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr;
  logic [RES_PTR_W-1:0]   rd_ptr;
  logic [RES_CNT_W-1:0]   count;
  logic                   do_pop;

  assign valid  = (count != '0);
  assign head   = mem[rd_ptr];
  assign do_pop = pop && valid;
  // two free slots so a value and a summary fit behind any waiting beat
  assign room   = (count <= RES_CNT_W'(RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.first;
    if (push.n == 2'd2) mem[wr_ptr + RES_PTR_W'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.n);
      if (do_pop) rd_ptr <= rd_ptr + RES_PTR_W'(1);
      count <= count + RES_CNT_W'(push.n) - RES_CNT_W'(do_pop);
    end
  end

  `SCP_ASSERT_IMP(a_no_overflow, 1'b1, count <= RES_CNT_W'(RES_DEPTH))
  `SCP_ASSERT_IMP(a_push_room, push.n != 2'd0, room)
  `SCP_ASSERT_IMP(a_push_n_legal, 1'b1, push.n != 2'd3)

endmodule

// ----- sv/slash_command_token_parser.sv -----
`timescale 1ns / 1ps
// channel  dir  beat contents
// cmd      in   char_in, end_of_message
// result   out  is_value, number, final_result, parse_ok, header fields, values_seen
//
// a byte is parsed in the cycle it is accepted; its results sit in a 4-entry queue
// from the next cycle on. one byte per cycle while cmd.ready is high; a byte that
// closes a value and ends the message makes two result beats, drained one per
// cycle while result.ready is high. cmd.ready drops while fewer than two
// queue slots are free. rst is synchronous and clears parser state and the queue.
module slash_command_token_parser
  import scp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  scp_cmd_if.sink  cmd,
  scp_res_if.source result
);

  push_t   push;
  result_t head;
  logic    room;
  logic    accept;

  assign cmd.ready = room;
  assign accept    = cmd.valid && room;

  scp_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .char_in        (cmd.char_in),
    .end_of_message (cmd.end_of_message),
    .push           (push)
  );

  scp_res_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (result.ready),
    .room  (room),
    .valid (result.valid),
    .head  (head)
  );

  assign result.is_value     = head.is_value;
  assign result.number       = head.number;
  assign result.final_result = head.final_result;
  assign result.parse_ok     = head.parse_ok;
  assign result.request_kind = head.request_kind;
  assign result.section      = head.section;
  assign result.detail_one   = head.detail_one;
  assign result.detail_two   = head.detail_two;
  assign result.values_seen  = head.values_seen;

endmodule

// ----- test/slash_command_token_parser_tb.sv -----
`timescale 1ns / 1ps
module slash_command_token_parser_tb;
  import scp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD_START, PH_HEAD_TOKEN, PH_VAL_START, PH_VAL_TOKEN, PH_DONE, PH_HALTED
  } parse_phase_t;

  typedef enum logic [1:0] {SCAN_BLANKS, SCAN_PLUS, SCAN_MINUS, SCAN_STOPPED} scan_t;

  localparam logic [15:0] CODE_GET    = "gt";
  localparam logic [15:0] CODE_POST   = "pt";
  localparam logic [15:0] CODE_PING   = "pg";
  localparam logic [15:0] CODE_TIME   = "tm";
  localparam logic [15:0] CODE_RELAY  = "rl";
  localparam logic [15:0] CODE_PIN    = "pn";
  localparam logic [15:0] CODE_MODE   = "md";
  localparam logic [15:0] CODE_ON     = "on";
  localparam logic [15:0] CODE_OFF    = "of";
  localparam logic [15:0] CODE_REPEAT = "rt";
  localparam logic [15:0] CODE_ACTIVE = "ac";

  localparam logic [1:0] KIND_NONE = 2'd0, KIND_GET = 2'd1, KIND_POST = 2'd2, KIND_PING = 2'd3;
  localparam logic [1:0] SECT_NONE = 2'd0, SECT_TIME = 2'd1, SECT_RELAY = 2'd2;
  localparam logic [1:0] DET1_NONE = 2'd0, DET1_PIN = 2'd1, DET1_MODE = 2'd2;
  localparam logic [2:0] DET2_NONE = 3'd0, DET2_ON = 3'd1, DET2_OFF = 3'd2;
  localparam logic [2:0] DET2_REPEAT = 3'd3, DET2_ACTIVE = 3'd4;

  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_EQUALS = "=";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_A      = "a";
  localparam logic [7:0] CH_Z      = "z";
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;

  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_BYTES = 120;

  logic clk = 1'b0;
  logic rst;

  always #10 clk = ~clk;

  scp_cmd_if cmd_bus ();
  scp_res_if res_bus ();

  slash_command_token_parser dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_bus),
    .result (res_bus)
  );

  // parser shadow state
  parse_phase_t phase;
  scan_t        scan;
  logic [3:0]   tok_len;
  logic [15:0]  head_pair;
  logic [15:0]  acc;
  logic         good;
  logic [1:0]   cur_kind;
  logic [1:0]   cur_sect;
  logic [1:0]   cur_det1;
  logic [2:0]   cur_det2;
  logic [3:0]   val_cnt;

  result_t results_due[$];
  logic [7:0] msg_buf[$];

  int  fail_count = 0;
  int  bytes_sent = 0;
  int  burst_left = 1;
  bit  sender_idles = 1'b1;
  logic [8:0] rx_tick = '0;

  function automatic void clear_message();
    phase     = PH_HEAD_START;
    scan      = SCAN_BLANKS;
    tok_len   = '0;
    head_pair = '0;
    acc       = '0;
    good      = 1'b1;
    cur_kind  = KIND_NONE;
    cur_sect  = SECT_NONE;
    cur_det1  = DET1_NONE;
    cur_det2  = DET2_NONE;
    val_cnt   = '0;
  endfunction

  function automatic void halt_message();
    good  = 1'b0;
    phase = PH_HALTED;
  endfunction

  function automatic result_t make_result(input logic isval, input logic [15:0] num,
                                          input logic fin, input logic ok);
    result_t r;
    r.is_value     = isval;
    r.number       = num;
    r.final_result = fin;
    r.parse_ok     = ok;
    r.request_kind = cur_kind;
    r.section      = cur_sect;
    r.detail_one   = cur_det1;
    r.detail_two   = cur_det2;
    r.values_seen  = val_cnt;
    return r;
  endfunction

  function automatic bit apply_header();
    if (tok_len != 4'd2) return 1'b0;
    case (head_pair)
      CODE_GET:    cur_kind = KIND_GET;
      CODE_POST:   cur_kind = KIND_POST;
      CODE_PING:   cur_kind = KIND_PING;
      CODE_TIME:   cur_sect = SECT_TIME;
      CODE_RELAY:  cur_sect = SECT_RELAY;
      CODE_PIN:    cur_det1 = DET1_PIN;
      CODE_MODE:   cur_det1 = DET1_MODE;
      CODE_ON:     cur_det2 = DET2_ON;
      CODE_OFF:    cur_det2 = DET2_OFF;
      CODE_REPEAT: cur_det2 = DET2_REPEAT;
      CODE_ACTIVE: cur_det2 = DET2_ACTIVE;
      default:     return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // atoi-style scan, wraps modulo 2^16
  function automatic void scan_number_byte(input logic [7:0] ch);
    logic        is_digit;
    logic        is_blank;
    logic [15:0] d;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    d = {8'd0, ch - CH_ZERO};
    case (scan)
      SCAN_BLANKS: if (!is_blank) begin
        if (ch == CH_PLUS) scan = SCAN_PLUS;
        else if (ch == CH_MINUS) scan = SCAN_MINUS;
        else if (is_digit) begin
          acc  = d;
          scan = SCAN_PLUS;
        end else scan = SCAN_STOPPED;
      end
      SCAN_PLUS: if (is_digit) acc = acc * 16'd10 + d; else scan = SCAN_STOPPED;
      SCAN_MINUS: if (is_digit) acc = acc * 16'd10 - d; else scan = SCAN_STOPPED;
      default: ;
    endcase
  endfunction

  function automatic bit take_token_byte(input logic [7:0] ch, input bit header);
    if (int'(tok_len) >= MAX_TOKEN_CHARS - 1) return 1'b0;
    if (header) begin
      if (tok_len == 4'd0) head_pair[15:8] = ch;
      else if (tok_len == 4'd1) head_pair[7:0] = ch;
    end else begin
      scan_number_byte(ch);
    end
    tok_len = tok_len + 4'd1;
    return 1'b1;
  endfunction

  function automatic void parse_command_byte(input logic [7:0] ch, input logic eom);
    case (phase)
      PH_HEAD_START: begin
        if (ch == CH_SLASH) phase = PH_DONE;
        else if (ch == CH_EQUALS) phase = PH_VAL_START;
        else begin
          tok_len   = '0;
          head_pair = '0;
          if (take_token_byte(ch, 1'b1)) phase = PH_HEAD_TOKEN; else halt_message();
        end
      end
      PH_HEAD_TOKEN: begin
        if (ch == CH_SLASH) begin
          if (apply_header()) phase = PH_HEAD_START; else halt_message();
        end else if (!take_token_byte(ch, 1'b1)) begin
          halt_message();
        end
      end
      PH_VAL_START: begin
        if (ch == CH_SLASH) phase = PH_DONE;
        else begin
          tok_len = '0;
          acc     = '0;
          scan    = SCAN_BLANKS;
          if (take_token_byte(ch, 1'b0)) phase = PH_VAL_TOKEN; else halt_message();
        end
      end
      PH_VAL_TOKEN: begin
        if (ch == CH_SLASH) begin
          if (int'(val_cnt) < MAX_VALUES) begin
            val_cnt = val_cnt + 4'd1;
            results_due.push_back(make_result(1'b1, acc, 1'b0, 1'b1));
            phase = PH_VAL_START;
          end else begin
            halt_message();
          end
        end else if (!take_token_byte(ch, 1'b0)) begin
          halt_message();
        end
      end
      default: ;
    endcase
    if (eom) begin
      if (phase != PH_DONE) good = 1'b0;
      results_due.push_back(make_result(1'b0, 16'd0, 1'b1, good));
      clear_message();
    end
  endfunction

  function automatic string result_text(input result_t r);
    return $sformatf("val=%0d num=%0d fin=%0d ok=%0d kind=%0d sect=%0d d1=%0d d2=%0d cnt=%0d",
                     r.is_value, r.number, r.final_result, r.parse_ok, r.request_kind,
                     r.section, r.detail_one, r.detail_two, r.values_seen);
  endfunction

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endfunction

  // result beats, checked in order
  always @(posedge clk) begin : check_result_beat
    result_t got;
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got = {res_bus.is_value, res_bus.number, res_bus.final_result, res_bus.parse_ok,
             res_bus.request_kind, res_bus.section, res_bus.detail_one, res_bus.detail_two,
             res_bus.values_seen};
      if (results_due.size() == 0) begin
        note_failure({"unexpected result: ", result_text(got)});
      end else begin
        want = results_due.pop_front();
        if (got !== want)
          note_failure({"mismatch: expected ", result_text(want), " got ", result_text(got)});
      end
    end
  end

  // receiver stall pattern, cycles through several modes
  always @(posedge clk) begin
    rx_tick <= rx_tick + 9'd1;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      case (rx_tick[8:6])
        3'd0, 3'd1: res_bus.ready <= 1'b1;
        3'd2, 3'd3: res_bus.ready <= ($urandom_range(0, 3) != 0);
        3'd4:       res_bus.ready <= (rx_tick[1:0] == 2'd0);
        3'd5:       res_bus.ready <= rx_tick[3];
        default:    res_bus.ready <= ($urandom_range(0, 4) < 2);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic eom);
    cmd_bus.valid          <= 1'b1;
    cmd_bus.char_in        <= ch;
    cmd_bus.end_of_message <= eom;
    do @(posedge clk); while (!cmd_bus.ready);
    parse_command_byte(ch, eom);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_idles) begin
        cmd_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_message();
    foreach (msg_buf[i]) send_byte(msg_buf[i], i == msg_buf.size() - 1);
    msg_buf.delete();
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_letter();
    return 8'($urandom_range(CH_A, CH_Z));
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [15:0] header_code(input int idx);
    case (idx)
      0:       return CODE_GET;
      1:       return CODE_POST;
      2:       return CODE_PING;
      3:       return CODE_TIME;
      4:       return CODE_RELAY;
      5:       return CODE_PIN;
      6:       return CODE_MODE;
      7:       return CODE_ON;
      8:       return CODE_OFF;
      9:       return CODE_REPEAT;
      default: return CODE_ACTIVE;
    endcase
  endfunction

  function automatic void put_code(input logic [15:0] code);
    msg_buf.push_back(code[15:8]);
    msg_buf.push_back(code[7:0]);
    msg_buf.push_back(CH_SLASH);
  endfunction

  // one value token without its closing slash
  function automatic void put_number_token(input bit overlong);
    logic [7:0] tok[$];
    logic [7:0] junk;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2))
        tok.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
    case ($urandom_range(0, 3))
      0:       tok.push_back(CH_PLUS);
      1:       tok.push_back(CH_MINUS);
      default: ;
    endcase
    repeat ($urandom_range(0, 6)) tok.push_back(any_digit());
    if ($urandom_range(0, 4) == 0) begin
      junk = 8'($urandom_range(0, 255));
      if (junk == CH_SLASH) junk = CH_EQUALS;
      tok.push_back(junk);
      tok.push_back(any_digit());
    end
    if (overlong) begin
      while (tok.size() < MAX_TOKEN_CHARS) tok.push_back(any_digit());
    end else begin
      while (tok.size() > MAX_TOKEN_CHARS - 1) void'(tok.pop_back());
    end
    if (tok.size() == 0) tok.push_back(any_digit());
    foreach (tok[i]) msg_buf.push_back(tok[i]);
  endfunction

  function automatic void build_random_message();
    int n_vals;
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 19))
        0: begin
          msg_buf.push_back(any_letter());
          msg_buf.push_back(any_letter());
          msg_buf.push_back(CH_SLASH);
        end
        1: begin
          msg_buf.push_back(any_letter());
          msg_buf.push_back(CH_SLASH);
        end
        2: begin
          repeat ($urandom_range(3, MAX_TOKEN_CHARS + 1)) msg_buf.push_back(any_letter());
          msg_buf.push_back(CH_SLASH);
        end
        default: put_code(header_code($urandom_range(0, 10)));
      endcase
    end
    if ($urandom_range(0, 4) != 0) begin
      msg_buf.push_back(CH_EQUALS);
      n_vals = ($urandom_range(0, 9) == 0) ? MAX_VALUES + 1 : $urandom_range(0, 4);
      repeat (n_vals) begin
        put_number_token($urandom_range(0, 19) == 0);
        msg_buf.push_back(CH_SLASH);
      end
    end
    case ($urandom_range(0, 9))
      0: ;  // message cut off before the terminator
      1: begin
        msg_buf.push_back(CH_SLASH);
        repeat ($urandom_range(1, 3)) msg_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: msg_buf.push_back(CH_SLASH);
    endcase
    if (msg_buf.size() == 0) msg_buf.push_back(CH_SLASH);
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 3))
        0:       msg_buf.push_back(8'($urandom_range(0, 255)));
        1:       msg_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_EQUALS);
        2:       msg_buf.push_back(any_letter());
        default: msg_buf.push_back(any_digit());
      endcase
    end
  endfunction

  task automatic test_directed();
    put_text("/");  // empty message, ends at once
    send_message();
    put_text("=-1/+65536//");  // wrap at both ends of the value range
    send_message();
    msg_buf.push_back(8'h00);
    msg_buf.push_back(8'hFF);
    msg_buf.push_back(CH_SLASH);
    send_message();
    put_text("=7/");  // value and summary out of the same beat
    send_message();
    put_text("md/ac");
    send_message();
    put_text("=12345678/");
    send_message();
  endtask

  task automatic test_header_codes();
    int order[11];
    int j;
    int t;
    foreach (order[i]) order[i] = i;
    foreach (order[i]) begin
      j = $urandom_range(0, 10);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) begin
      put_code(header_code(order[i]));
      if (i % 3 == 2 || i == 10) begin
        msg_buf.push_back(CH_SLASH);
        send_message();
      end
    end
  endtask

  task automatic test_value_limits();
    for (int rep = 0; rep < 4; rep++) begin
      put_code(header_code($urandom_range(0, 10)));
      msg_buf.push_back(CH_EQUALS);
      repeat ((rep % 2 == 0) ? MAX_VALUES : MAX_VALUES + 1) begin
        put_number_token(1'b0);
        msg_buf.push_back(CH_SLASH);
      end
      msg_buf.push_back(CH_SLASH);
      send_message();
    end
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      build_random_message();
      send_message();
      cmd_bus.valid <= 1'b0;
      do @(posedge clk); while (results_due.size() != 0);
    end
  endtask

  task automatic test_random_messages();
    int start_count;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) build_noise(); else build_random_message();
      send_message();
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    clear_message();
    rst                    <= 1'b1;
    cmd_bus.valid          <= 1'b0;
    cmd_bus.char_in        <= 8'd0;
    cmd_bus.end_of_message <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_header_codes();
    test_value_limits();
    test_drain_pause();
    test_random_messages();

    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (8) @(posedge clk);
    if (results_due.size() != 0) note_failure("results still outstanding");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/scp_pkg.sv
sv/scp_cmd_if.sv
sv/scp_res_if.sv
sv/scp_core.sv
sv/scp_res_queue.sv
sv/slash_command_token_parser.sv
test/slash_command_token_parser_tb.sv
